/* sv/byte_range_block_splitter_defines.svh */
// Assertion macros for the splitter RTL, included by brbs_back.
// Both expect clk and rst_n in scope.
`ifndef BYTE_RANGE_BLOCK_SPLITTER_DEFINES_SVH
`define BYTE_RANGE_BLOCK_SPLITTER_DEFINES_SVH

// Same-cycle implication
`define BRBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BRBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/brbs_pkg.sv */
`default_nettype none
package brbs_pkg;

  localparam int BS_MAX    = 65536;
  localparam int DIV_STEPS = 49;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_BLOCK_BYTES = 2'd0,
    CFG_BLOCK_TOTAL = 2'd1,
    CFG_BASE_LBA    = 2'd2,
    CFG_WRITABLE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_DIV  = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  // Command slots of one request, in issue order
  typedef enum logic [2:0] {
    SLOT_FIRST_RD = 3'd0,
    SLOT_FIRST_WR = 3'd1,
    SLOT_MID      = 3'd2,
    SLOT_LAST_RD  = 3'd3,
    SLOT_LAST_WR  = 3'd4
  } slot_t;

  typedef struct packed {
    logic [16:0] block_bytes;
    logic [31:0] block_total;
    logic [47:0] base_lba;
    logic        writable;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic        rej;
    logic        cmd;
    logic        has_first;
    logic        has_mid;
    logic        has_last;
    logic [47:0] head_lba;
    logic [15:0] head_off;
    logic [15:0] head_len;
    logic [47:0] mid_lba;
    logic [31:0] mid_cnt;
    logic [47:0] tail_lba;
    logic [15:0] tail_len;
    logic [47:0] last_buf;
  } entry_t;

endpackage
`default_nettype wire

/* sv/brbs_div.sv */
`default_nettype none
// Two-lane restoring divider, one quotient bit per cycle, shared divisor
module brbs_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] divisor,
  input  wire logic [48:0] dvd_a,
  input  wire logic [48:0] dvd_b,
  output logic             done,
  output logic [48:0]      quo_a,
  output logic [16:0]      rem_a,
  output logic [48:0]      quo_b,
  output logic [16:0]      rem_b
);
  import brbs_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [16:0]      div_r;
  logic [48:0]      qa_r, qb_r;
  logic [16:0]      ra_r, rb_r;

  logic [17:0] tmp_a, tmp_b;
  logic        ge_a, ge_b;
  logic [16:0] ra_nxt, rb_nxt;

  // Trial subtract per lane
  always_comb begin
    tmp_a  = {ra_r, qa_r[48]};
    tmp_b  = {rb_r, qb_r[48]};
    ge_a   = tmp_a >= {1'b0, div_r};
    ge_b   = tmp_b >= {1'b0, div_r};
    ra_nxt = ge_a ? 17'(tmp_a - {1'b0, div_r}) : tmp_a[16:0];
    rb_nxt = ge_b ? 17'(tmp_b - {1'b0, div_r}) : tmp_b[16:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      qa_r  <= dvd_a;
      qb_r  <= dvd_b;
      ra_r  <= '0;
      rb_r  <= '0;
    end else if (busy_r) begin
      qa_r <= {qa_r[47:0], ge_a};
      qb_r <= {qb_r[47:0], ge_b};
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  assign done  = done_r;
  assign quo_a = qa_r;
  assign rem_a = ra_r;
  assign quo_b = qb_r;
  assign rem_b = rb_r;

endmodule
`default_nettype wire

/* sv/brbs_front.sv */
`default_nettype none
// Accepts requests, checks range, divides start and end by block size
module brbs_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [95:0]     in_tdata,   // byte_offset[47:0], byte_length[95:48]
  input  wire logic [0:0]      in_tuser,   // command[0]
  input  wire brbs_pkg::cfg_t  cfg,
  input  wire logic            q_full,
  output logic                 q_push,
  output brbs_pkg::entry_t     q_wdata
);
  import brbs_pkg::*;

  front_state_t state_r, state_nxt;

  logic        hold_v_r;
  logic        hold_cmd_r;
  logic [47:0] hold_off_r, hold_len_r;
  logic [48:0] cap_r;
  logic [16:0] bs_r;
  logic        job_cmd_r;
  logic [47:0] job_len_r;
  logic [16:0] job_bs_r;

  logic        consume, start;
  logic [48:0] end_w;
  logic        rej;
  logic [16:0] bs_clamp;

  logic        div_done;
  logic [48:0] quo_a, quo_b;
  logic [16:0] rem_a, rem_b;

  logic        r0nz, rest;
  logic [48:0] mid49;
  logic [15:0] head_len;
  logic [31:0] mid_cnt;
  entry_t      done_e;

  // Capacity is registered from config and follows it in the next cycle
  always_comb begin
    bs_clamp = (cfg.block_bytes > 17'(BS_MAX)) ? 17'(BS_MAX) : cfg.block_bytes;
  end

  always_ff @(posedge clk) begin
    bs_r  <= bs_clamp;
    cap_r <= 49'(cfg.block_total * bs_clamp);
  end

  // Input holding stage
  assign in_tready = !hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      hold_v_r <= 1'b1;
    end else if (consume) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_cmd_r <= in_tuser[0];
      hold_off_r <= in_tdata[47:0];
      hold_len_r <= in_tdata[95:48];
    end
  end

  // Range check
  always_comb begin
    end_w = {1'b0, hold_off_r} + {1'b0, hold_len_r};
    rej   = (hold_len_r == '0) || (hold_cmd_r && !cfg.writable) ||
            ({1'b0, hold_off_r} >= cap_r) || (end_w > cap_r);
  end

  // Classify from quotients and remainders
  always_comb begin
    r0nz      = rem_a != '0;
    mid49     = {1'b0, quo_a[47:0]} + {48'b0, r0nz};
    rest      = (quo_b > mid49) || (r0nz && quo_b == mid49 && rem_b[15:0] != '0);
    head_len  = rest ? (r0nz ? 16'(job_bs_r - rem_a) : 16'd0) : job_len_r[15:0];
    mid_cnt   = 32'(quo_b - mid49);
    done_e           = '0;
    done_e.cmd       = job_cmd_r;
    done_e.has_first = head_len != '0;
    done_e.has_mid   = rest && mid_cnt != '0;
    done_e.has_last  = rest && rem_b[15:0] != '0;
    done_e.head_lba  = quo_a[47:0];
    done_e.head_off  = rem_a[15:0];
    done_e.head_len  = head_len;
    done_e.mid_lba   = mid49[47:0];
    done_e.mid_cnt   = mid_cnt;
    done_e.tail_lba  = quo_b[47:0];
    done_e.tail_len  = rem_b[15:0];
    done_e.last_buf  = job_len_r - {32'b0, rem_b[15:0]};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    consume     = 1'b0;
    start       = 1'b0;
    q_push      = 1'b0;
    q_wdata     = done_e;
    unique case (state_r)
      F_IDLE: begin
        if (hold_v_r) begin
          if (rej) begin
            q_wdata     = '0;
            q_wdata.rej = 1'b1;
            if (!q_full) begin
              q_push  = 1'b1;
              consume = 1'b1;
            end
          end else begin
            start     = 1'b1;
            consume   = 1'b1;
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (div_done) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_cmd_r <= hold_cmd_r;
      job_len_r <= hold_len_r;
      job_bs_r  <= bs_r;
    end
  end

  brbs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .divisor (bs_r),
    .dvd_a   ({1'b0, hold_off_r}),
    .dvd_b   (end_w),
    .done    (div_done),
    .quo_a   (quo_a),
    .rem_a   (rem_a),
    .quo_b   (quo_b),
    .rem_b   (rem_b)
  );

endmodule
`default_nettype wire

/* sv/brbs_fifo.sv */
`default_nettype none
// Short queue of classified requests between front and back
module brbs_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire brbs_pkg::entry_t  wdata,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output brbs_pkg::entry_t       rdata
);
  import brbs_pkg::*;

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign valid = cnt_r != '0;
  assign rdata = mem_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

/* sv/brbs_back.sv */
`default_nettype none
`include "byte_range_block_splitter_defines.svh"
// Walks each queued request through its block commands, one per cycle unless out_tready stalls
module brbs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire brbs_pkg::entry_t  q_rdata,
  output logic                   q_pop,
  input  wire logic [47:0]       base_lba,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [167:0]           out_tdata,  // lba, block_count, block_offset,
                                             // piece_length, buffer_offset
  output logic [1:0]             out_tuser,  // kind[1:0]
  output logic                   out_tlast
);
  import brbs_pkg::*;

  logic [2:0]  slot_r;
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [48:0] out_lba_r;
  logic [31:0] out_cnt_r;
  logic [15:0] out_boff_r, out_plen_r;
  logic [47:0] out_buf_r;
  logic        out_last_r;

  logic [4:0]  mask, avail, low;
  logic [2:0]  sel;
  logic        more, is_last, load;
  kind_t       r_kind;
  logic [48:0] r_lba;
  logic [31:0] r_cnt;
  logic [15:0] r_boff, r_plen;
  logic [47:0] r_buf;
  kind_t       cmd_kind;

  // Pick the next present slot at or after the current one
  always_comb begin
    mask = {q_rdata.has_last & q_rdata.cmd, q_rdata.has_last, q_rdata.has_mid,
            q_rdata.has_first & q_rdata.cmd, q_rdata.has_first};
    for (int i = 0; i < 5; i++) begin
      avail[i] = mask[i] && (3'(i) >= slot_r);
    end
    low  = avail & (~avail + 5'd1);
    sel  = '0;
    for (int i = 4; i >= 0; i--) begin
      if (low[i]) sel = 3'(i);
    end
    more    = (avail & ~low) != '0;
    is_last = q_rdata.rej || !more;
    load    = q_valid && (!out_valid_r || out_tready);
    q_pop   = load && is_last;
  end

  // Result fields of the selected command
  always_comb begin
    cmd_kind = q_rdata.cmd ? KIND_WRITE : KIND_READ;
    r_kind   = KIND_READ;
    r_lba    = '0;
    r_cnt    = 32'd1;
    r_boff   = '0;
    r_plen   = '0;
    r_buf    = '0;
    if (q_rdata.rej) begin
      r_kind = KIND_REJECT;
      r_cnt  = '0;
    end else begin
      unique case (sel)
        SLOT_FIRST_RD, SLOT_FIRST_WR: begin
          r_kind = (sel == SLOT_FIRST_WR) ? KIND_WRITE : KIND_READ;
          r_lba  = {1'b0, base_lba} + {1'b0, q_rdata.head_lba};
          r_boff = q_rdata.head_off;
          r_plen = q_rdata.head_len;
        end
        SLOT_MID: begin
          r_kind = cmd_kind;
          r_lba  = {1'b0, base_lba} + {1'b0, q_rdata.mid_lba};
          r_cnt  = q_rdata.mid_cnt;
          r_buf  = {32'b0, q_rdata.head_len};
        end
        SLOT_LAST_RD, SLOT_LAST_WR: begin
          r_kind = (sel == SLOT_LAST_WR) ? KIND_WRITE : KIND_READ;
          r_lba  = {1'b0, base_lba} + {1'b0, q_rdata.tail_lba};
          r_plen = q_rdata.tail_len;
          r_buf  = q_rdata.last_buf;
        end
        default: r_kind = KIND_READ;
      endcase
    end
  end

  // Slot counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= SLOT_FIRST_RD;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        slot_r      <= is_last ? 3'(SLOT_FIRST_RD) : 3'(sel + 3'd1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= r_kind;
      out_lba_r  <= r_lba;
      out_cnt_r  <= r_cnt;
      out_boff_r <= r_boff;
      out_plen_r <= r_plen;
      out_buf_r  <= r_buf;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_buf_r, out_plen_r, out_boff_r, out_cnt_r, out_lba_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `BRBS_ASSERT_IMPL(a_rej_last, out_valid_r && out_kind_r == KIND_REJECT, out_last_r,
    "reject transaction without last")
  `BRBS_ASSERT_IMPL(a_slot_held, slot_r != 3'(SLOT_FIRST_RD), q_valid,
    "request left the queue before its last command")
  `BRBS_ASSERT_IMPL(a_one_slot, load && !q_rdata.rej, $onehot(low),
    "queued request has no command to issue")

endmodule
`default_nettype wire

/* sv/byte_range_block_splitter.sv */
// Requests are divided one at a time by the 49-step two-lane restoring
// divider in the front; the input holding stage can take the next request
// while a division runs. Commands leave one per cycle unless out_tready stalls.
// A queued request emits up to five commands back to back.
// Reset (rst_n, synchronous, active low) clears control state and
// restores config to block_bytes 512, other registers 0.
`default_nettype none
module byte_range_block_splitter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [95:0]   in_tdata,   // byte_offset[47:0], byte_length[95:48]
  input  wire logic [0:0]    in_tuser,   // command[0]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [167:0]       out_tdata,  // lba[48:0], block_count[80:49],
                                         // block_offset[96:81], piece_length[112:97],
                                         // buffer_offset[160:113]
  output logic [1:0]         out_tuser,  // kind[1:0]
  output logic               out_tlast,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [47:0]   cfg_data
);
  import brbs_pkg::*;

  cfg_t   cfg_r;
  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_wdata, q_rdata;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_bytes <= 17'd512;
      cfg_r.block_total <= '0;
      cfg_r.base_lba    <= '0;
      cfg_r.writable    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLOCK_BYTES: cfg_r.block_bytes <= cfg_data[16:0];
        CFG_BLOCK_TOTAL: cfg_r.block_total <= cfg_data[31:0];
        CFG_BASE_LBA:    cfg_r.base_lba    <= cfg_data;
        CFG_WRITABLE:    cfg_r.writable    <= cfg_data[0];
        default:         cfg_r.writable    <= cfg_r.writable;
      endcase
    end
  end

  brbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  brbs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  brbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .base_lba   (cfg_r.base_lba),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
